@@ hw/rtl/sutc_pkg.sv @@
package sutc_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_INTERVAL  = 2'd0;
  localparam logic [1:0] REG_START     = 2'd1;
  localparam logic [1:0] REG_TOLERANCE = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [31:0] INTERVAL_RST  = 32'd4001416;
  localparam logic [63:0] START_RST     = 64'd0;
  localparam logic [31:0] TOLERANCE_RST = 32'd500000;

  // Iteration counts of the shared multiply and divide loops.
  localparam int MUL_STEPS = 32;
  localparam int DIV_STEPS = 64;
  localparam int CNT_W     = 6;

  localparam int POS_W = 48;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UNWRAP,
    ST_MUL,
    ST_TS,
    ST_GAP,
    ST_HALF,
    ST_DIV,
    ST_KFIX,
    ST_ERR1,
    ST_ERR2,
    ST_CMP,
    ST_FINISH
  } st_t;

endpackage

@@ hw/rtl/seq_unwrap_timestamp_checker_unit.sv @@
// Sequence unwrapper and packet timestamp checker sharing one 64-bit adder.
// A request with the start time unset skips straight to the finish state; otherwise the
// sequence is unwrapped and stamped, and a checked packet adds a grid check (32-step multiply,
// 64-step divide, second 32-step multiply); the result waits while the output register is full.
// Requests are taken one at a time; the next is taken the cycle after the result is loaded.
// Reset (rst_n low, synchronous) loads the register defaults and clears sequencer and state.
module seq_unwrap_timestamp_checker_unit
  import sutc_pkg::*;
#(
  parameter int INDEX_WIDTH = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [63:0] cfg_wdata,
  // Input channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_seq_number,
  input  logic        in_payload_complete,
  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_pkt_time_ns,
  output logic        out_delivered,
  output logic        out_timing_jump,
  output logic [47:0] out_packet_position,
  output logic [31:0] out_processed_count
);

  // Configuration registers.
  logic [31:0] interval_r;
  logic [63:0] start_r;
  logic [31:0] tol_r;

  // Stream state.
  logic                   seen_r, seen_nxt;
  logic [15:0]            last_seq_r, last_seq_nxt;
  logic [INDEX_WIDTH-1:0] index_r, index_nxt;
  logic [31:0]            count_r, count_nxt;
  logic [63:0]            last_chk_r, last_chk_nxt;

  // Working registers of the sequencer.
  st_t              state_r, state_nxt;
  logic [15:0]      seq_r, seq_nxt;
  logic             cmpl_r, cmpl_nxt;
  logic [63:0]      acc_r, acc_nxt;
  logic [63:0]      mcand_r, mcand_nxt;
  logic [31:0]      mplier_r, mplier_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             mul_exp_r, mul_exp_nxt;
  logic [63:0]      ts_r, ts_nxt;
  logic [63:0]      gap_r, gap_nxt;
  logic [63:0]      num_r, num_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic [63:0]      err_r, err_nxt;
  logic             dlv_r, dlv_nxt;
  logic             jump_r, jump_nxt;

  // Output register.
  logic        ov_r, ov_nxt;
  logic [63:0] o_ts_r, o_ts_nxt;
  logic        o_dlv_r, o_dlv_nxt;
  logic        o_jump_r, o_jump_nxt;
  logic [47:0] o_pos_r, o_pos_nxt;
  logic [31:0] o_cnt_r, o_cnt_nxt;

  // Shared adder/subtractor.
  logic [63:0] alu_a, alu_b;
  logic        alu_sub;
  logic [64:0] alu_sum;
  logic        alu_borrow;

  logic [15:0] delta;
  logic [32:0] rem_sh;
  logic        div_ge;
  logic [63:0] index_ext;

  assign alu_sum    = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + {64'd0, alu_sub};
  assign alu_borrow = alu_sub & ~alu_sum[64];

  assign delta     = seq_r - last_seq_r;
  assign rem_sh    = {rem_r, num_r[63]};
  assign div_ge    = ~alu_borrow;
  assign index_ext = 64'(index_r);

  assign in_ready            = (state_r == ST_IDLE);
  assign out_valid           = ov_r;
  assign out_pkt_time_ns     = o_ts_r;
  assign out_delivered       = o_dlv_r;
  assign out_timing_jump     = o_jump_r;
  assign out_packet_position = o_pos_r;
  assign out_processed_count = o_cnt_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= INTERVAL_RST;
      start_r    <= START_RST;
      tol_r      <= TOLERANCE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_INTERVAL:  interval_r <= cfg_wdata[31:0];
        REG_START:     start_r    <= cfg_wdata;
        REG_TOLERANCE: tol_r      <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control and stream state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= 1'b0;
      last_seq_r <= '0;
      index_r    <= '0;
      count_r    <= '0;
      last_chk_r <= '0;
      ov_r       <= 1'b0;
      cnt_r      <= '0;
      mul_exp_r  <= 1'b0;
    end else begin
      seen_r     <= seen_nxt;
      last_seq_r <= last_seq_nxt;
      index_r    <= index_nxt;
      count_r    <= count_nxt;
      last_chk_r <= last_chk_nxt;
      ov_r       <= ov_nxt;
      cnt_r      <= cnt_nxt;
      mul_exp_r  <= mul_exp_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    seq_r    <= seq_nxt;
    cmpl_r   <= cmpl_nxt;
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    ts_r     <= ts_nxt;
    gap_r    <= gap_nxt;
    num_r    <= num_nxt;
    rem_r    <= rem_nxt;
    err_r    <= err_nxt;
    dlv_r    <= dlv_nxt;
    jump_r   <= jump_nxt;
    o_ts_r   <= o_ts_nxt;
    o_dlv_r  <= o_dlv_nxt;
    o_jump_r <= o_jump_nxt;
    o_pos_r  <= o_pos_nxt;
    o_cnt_r  <= o_cnt_nxt;
  end

  // Next state and datapath control.
  always_comb begin
    state_nxt    = state_r;
    seen_nxt     = seen_r;
    last_seq_nxt = last_seq_r;
    index_nxt    = index_r;
    count_nxt    = count_r;
    last_chk_nxt = last_chk_r;
    seq_nxt      = seq_r;
    cmpl_nxt     = cmpl_r;
    acc_nxt      = acc_r;
    mcand_nxt    = mcand_r;
    mplier_nxt   = mplier_r;
    cnt_nxt      = cnt_r;
    mul_exp_nxt  = mul_exp_r;
    ts_nxt       = ts_r;
    gap_nxt      = gap_r;
    num_nxt      = num_r;
    rem_nxt      = rem_r;
    err_nxt      = err_r;
    dlv_nxt      = dlv_r;
    jump_nxt     = jump_r;
    ov_nxt       = ov_r;
    o_ts_nxt     = o_ts_r;
    o_dlv_nxt    = o_dlv_r;
    o_jump_nxt   = o_jump_r;
    o_pos_nxt    = o_pos_r;
    o_cnt_nxt    = o_cnt_r;
    alu_a        = '0;
    alu_b        = '0;
    alu_sub      = 1'b0;

    // The consumer frees the output register.
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          seq_nxt  = in_seq_number;
          cmpl_nxt = in_payload_complete;
          ts_nxt   = '0;
          dlv_nxt  = 1'b0;
          jump_nxt = 1'b0;
          state_nxt = (start_r == 64'd0) ? ST_FINISH : ST_UNWRAP;
        end
      end

      // Unwrap the sequence number and start the timestamp multiply.
      ST_UNWRAP: begin
        alu_a = index_ext;
        alu_b = (delta != 16'd0 && !delta[15]) ? 64'(delta) : 64'd1;
        if (!seen_r) begin
          seen_nxt     = 1'b1;
          last_seq_nxt = seq_r;
          index_nxt    = '0;
        end else begin
          index_nxt = alu_sum[INDEX_WIDTH-1:0];
          if (delta != 16'd0 && !delta[15]) begin
            last_seq_nxt = seq_r;
          end
        end
        count_nxt   = count_r + 32'd1;
        acc_nxt     = '0;
        mcand_nxt   = 64'(index_nxt);
        mplier_nxt  = interval_r;
        cnt_nxt     = '0;
        mul_exp_nxt = 1'b0;
        state_nxt   = ST_MUL;
      end

      // One shift-add step of the product modulo 2^64.
      ST_MUL: begin
        alu_a      = acc_r;
        alu_b      = mplier_r[0] ? mcand_r : 64'd0;
        acc_nxt    = alu_sum[63:0];
        mcand_nxt  = {mcand_r[62:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[31:1]};
        cnt_nxt    = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(MUL_STEPS - 1)) begin
          state_nxt = mul_exp_r ? ST_ERR1 : ST_TS;
        end
      end

      // Add the stream origin and decide whether a grid check follows.
      ST_TS: begin
        alu_a  = acc_r;
        alu_b  = start_r;
        ts_nxt = alu_sum[63:0];
        if (alu_sum[63:0] != 64'd0 && cmpl_r) begin
          dlv_nxt = 1'b1;
          if (last_chk_r != 64'd0 && interval_r != 32'd0) begin
            state_nxt = ST_GAP;
          end else begin
            last_chk_nxt = alu_sum[63:0];
            state_nxt    = ST_FINISH;
          end
        end else begin
          state_nxt = ST_FINISH;
        end
      end

      // Gap since the last checked timestamp; a gap that is not positive is a jump.
      ST_GAP: begin
        alu_a        = ts_r;
        alu_b        = last_chk_r;
        alu_sub      = 1'b1;
        gap_nxt      = alu_sum[63:0];
        last_chk_nxt = ts_r;
        if (alu_sum[63:0] == 64'd0 || alu_sum[63]) begin
          jump_nxt  = 1'b1;
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_HALF;
        end
      end

      // Round to nearest: the dividend is the gap plus half an interval.
      ST_HALF: begin
        alu_a     = gap_r;
        alu_b     = 64'({1'b0, interval_r[31:1]});
        num_nxt   = alu_sum[63:0];
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end

      // One restoring divide step; the quotient shifts into the dividend register.
      ST_DIV: begin
        alu_a   = 64'(rem_sh);
        alu_b   = 64'(interval_r);
        alu_sub = 1'b1;
        rem_nxt = div_ge ? alu_sum[31:0] : rem_sh[31:0];
        num_nxt = {num_r[62:0], div_ge};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_KFIX;
        end
      end

      // Clamp the multiple to at least one and start the expected-gap multiply.
      ST_KFIX: begin
        acc_nxt     = '0;
        mcand_nxt   = (num_r == 64'd0) ? 64'd1 : num_r;
        mplier_nxt  = interval_r;
        cnt_nxt     = '0;
        mul_exp_nxt = 1'b1;
        state_nxt   = ST_MUL;
      end

      // Deviation from the grid, first as gap minus expected.
      ST_ERR1: begin
        alu_a   = gap_r;
        alu_b   = acc_r;
        alu_sub = 1'b1;
        err_nxt = alu_sum[63:0];
        state_nxt = alu_borrow ? ST_ERR2 : ST_CMP;
      end

      // The expected gap was larger: take expected minus gap.
      ST_ERR2: begin
        alu_a     = acc_r;
        alu_b     = gap_r;
        alu_sub   = 1'b1;
        err_nxt   = alu_sum[63:0];
        state_nxt = ST_CMP;
      end

      // A deviation above the tolerance is a jump.
      ST_CMP: begin
        alu_a     = 64'(tol_r);
        alu_b     = err_r;
        alu_sub   = 1'b1;
        jump_nxt  = alu_borrow;
        state_nxt = ST_FINISH;
      end

      // Load the result once the output register is free.
      ST_FINISH: begin
        if (!ov_r || out_ready) begin
          ov_nxt     = 1'b1;
          o_ts_nxt   = ts_r;
          o_dlv_nxt  = dlv_r;
          o_jump_nxt = jump_r;
          o_pos_nxt  = index_ext[POS_W-1:0];
          o_cnt_nxt  = count_r;
          state_nxt  = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ tb/seq_unwrap_timestamp_checker_unit_tb.sv @@
`timescale 1ns / 100ps

module seq_unwrap_timestamp_checker_unit_tb;
  import sutc_pkg::*;

  // One result as the block reports it.
  typedef struct packed {
    logic [63:0]      ts;
    logic             delivered;
    logic             jump;
    logic [POS_W-1:0] pos;
    logic [31:0]      count;
  } pkt_result_t;

  // A row of the directed table is either a packet request or a register write.
  typedef enum logic {ROW_PKT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  addr;
    logic [63:0] data;
    logic [15:0] seq;
    logic        cmpl;
    bit          typed;
    pkt_result_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = REG_INTERVAL;
  logic [63:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_seq_number = '0;
  logic        in_payload_complete = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_pkt_time_ns;
  logic        out_delivered;
  logic        out_timing_jump;
  logic [47:0] out_packet_position;
  logic [31:0] out_processed_count;

  // Hand-written expectation that travels with the request on the wire.
  bit          drv_typed = 1'b0;
  pkt_result_t drv_typed_res = '0;

  // Idle and stall chances in percent.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned mismatch_count = 0;
  pkt_result_t pending_results[$];

  // Shadow configuration and unwrap state.
  logic [31:0]      pr_interval = INTERVAL_RST;
  logic [63:0]      pr_start = START_RST;
  logic [31:0]      pr_tol = TOLERANCE_RST;
  logic             pr_seen = 1'b0;
  logic [15:0]      pr_last_seq = '0;
  logic [POS_W-1:0] pr_index = '0;
  logic [31:0]      pr_count = '0;
  logic [63:0]      pr_last_checked = '0;

  dir_row_t dir_rows[$];

  seq_unwrap_timestamp_checker_unit u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_addr            (cfg_addr),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_seq_number       (in_seq_number),
    .in_payload_complete (in_payload_complete),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_pkt_time_ns     (out_pkt_time_ns),
    .out_delivered       (out_delivered),
    .out_timing_jump     (out_timing_jump),
    .out_packet_position (out_packet_position),
    .out_processed_count (out_processed_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Unwraps one packet, stamps it and checks its gap against the interval grid when the start time is set.
  function automatic pkt_result_t predict_packet(input logic [15:0] seq, input logic cmpl);
    pkt_result_t r;
    logic [15:0] d;
    logic [63:0] gap;
    logic [63:0] k;
    logic [63:0] grid;
    logic [63:0] err;
    logic        positive;
    r = '0;
    if (pr_start != 64'd0) begin
      if (!pr_seen) begin
        pr_seen = 1'b1;
        pr_last_seq = seq;
        pr_index = '0;
      end else begin
        d = seq - pr_last_seq;
        // Only a forward step of less than half the sequence space moves last_seq.
        if (d != 16'd0 && !d[15]) begin
          pr_index = pr_index + POS_W'(d);
          pr_last_seq = seq;
        end else begin
          pr_index = pr_index + POS_W'(1);
        end
      end
      pr_count = pr_count + 32'd1;
      r.ts = pr_start + 64'(pr_index) * 64'(pr_interval);
      if (r.ts != 64'd0 && cmpl) begin
        r.delivered = 1'b1;
        if (pr_last_checked != 64'd0 && pr_interval != 32'd0) begin
          gap = r.ts - pr_last_checked;
          positive = (gap != 64'd0) && !gap[63];
          k = 64'd1;
          if (positive) begin
            k = (gap + 64'(pr_interval >> 1)) / 64'(pr_interval);
            if (k == 64'd0) k = 64'd1;
          end
          grid = k * 64'(pr_interval);
          err = (gap >= grid) ? gap - grid : grid - gap;
          r.jump = !positive || (err > 64'(pr_tol));
        end
        pr_last_checked = r.ts;
      end
    end
    r.pos = pr_index;
    r.count = pr_count;
    return r;
  endfunction

  function automatic dir_row_t row_pkt(input logic [15:0] seq, input logic cmpl);
    dir_row_t r;
    r = '{kind: ROW_PKT, addr: REG_INTERVAL, data: '0, seq: seq, cmpl: cmpl,
          typed: 1'b0, res: '0};
    return r;
  endfunction

  function automatic dir_row_t row_cfg(input logic [1:0] addr, input logic [63:0] data);
    dir_row_t r;
    r = '{kind: ROW_CFG, addr: addr, data: data, seq: '0, cmpl: 1'b0,
          typed: 1'b0, res: '0};
    return r;
  endfunction

  function automatic dir_row_t row_typed(input logic [15:0] seq, input logic cmpl,
                                         input logic [63:0] ts, input logic del,
                                         input logic jump, input logic [POS_W-1:0] pos,
                                         input logic [31:0] cnt);
    dir_row_t r;
    r = row_pkt(seq, cmpl);
    r.typed = 1'b1;
    r.res = '{ts: ts, delivered: del, jump: jump, pos: pos, count: cnt};
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // Presents one request from a falling edge and returns at the falling edge after
  // it is taken; valid stays high so that the next request can follow at once.
  task automatic send_pkt(input logic [15:0] seq, input logic cmpl, input bit typed,
                          input pkt_result_t res);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_seq_number <= seq;
    in_payload_complete <= cmpl;
    drv_typed <= typed;
    drv_typed_res <= res;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drops valid and waits until every outstanding request has its result back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] addr, input logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Receiver: random back-pressure, decided at each falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Tracks register writes, predicts each accepted request, checks each result.
  always @(posedge clk) begin : scoreboard
    pkt_result_t exp_r;
    pkt_result_t pred;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_INTERVAL:  pr_interval = cfg_wdata[31:0];
          REG_START:     pr_start = cfg_wdata;
          REG_TOLERANCE: pr_tol = cfg_wdata[31:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with no request pending: expected none, actual ts 0x%0h",
                   $time, out_pkt_time_ns);
          mismatch_count++;
        end else begin
          exp_r = pending_results.pop_front();
          compare_field("pkt_time_ns", exp_r.ts, out_pkt_time_ns);
          compare_field("delivered", 64'(exp_r.delivered), 64'(out_delivered));
          compare_field("timing_jump", 64'(exp_r.jump), 64'(out_timing_jump));
          compare_field("packet_position", 64'(exp_r.pos), 64'(out_packet_position));
          compare_field("processed_count", 64'(exp_r.count), 64'(out_processed_count));
        end
      end
      if (in_valid && in_ready) begin
        pred = predict_packet(in_seq_number, in_payload_complete);
        pending_results.push_back(drv_typed ? drv_typed_res : pred);
      end
    end
  end

  // Main stimulus.
  initial begin
    logic [31:0] ival;
    logic [31:0] tol;
    logic [63:0] start;
    logic [15:0] gen_seq;
    logic [15:0] seq;
    logic        cmpl;
    int unsigned r;

    dir_rows = '{
      // Start time unset: nothing stamped, state untouched.
      row_typed(16'h0000, 1'b1, 64'd0, 1'b0, 1'b0, '0, 32'd0),
      row_typed(16'hFFFF, 1'b0, 64'd0, 1'b0, 1'b0, '0, 32'd0),
      row_cfg(REG_INTERVAL, 64'd100),
      row_cfg(REG_TOLERANCE, 64'd0),
      row_cfg(REG_START, 64'd1000),
      // First packet sets the origin of the index.
      row_typed(16'hFFFE, 1'b1, 64'd1000, 1'b1, 1'b0, '0, 32'd1),
      row_pkt(16'hFFFF, 1'b1),
      row_pkt(16'h0001, 1'b1),   // forward across the sequence wrap
      row_pkt(16'h0001, 1'b1),   // duplicate
      row_pkt(16'h0000, 1'b1),   // reordered
      row_pkt(16'h8001, 1'b1),   // delta of exactly half the space
      row_pkt(16'h8000, 1'b0),   // largest forward delta, incomplete payload
      row_pkt(16'h8001, 1'b1),
      row_cfg(REG_START, 64'd1010),
      row_pkt(16'h8002, 1'b1),   // off grid with zero tolerance
      row_cfg(REG_TOLERANCE, 64'hFFFF_FFFF),
      row_pkt(16'h8003, 1'b1),
      row_cfg(REG_START, 64'd5),
      row_pkt(16'h8004, 1'b1),   // gap goes negative
      row_cfg(REG_INTERVAL, 64'd0),
      row_pkt(16'h8005, 1'b1),   // no grid at all
      row_cfg(REG_INTERVAL, 64'hFFFF_FFFF),
      row_cfg(REG_START, 64'hFFFF_FFFF_FFFF_FFFF),
      row_pkt(16'h8006, 1'b1),
      row_pkt(16'h7FFF, 1'b0),
      row_cfg(REG_START, 64'd0),
      row_pkt(16'h1234, 1'b1)
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_cfg(dir_rows[i].addr, dir_rows[i].data);
      end else begin
        send_pkt(dir_rows[i].seq, dir_rows[i].cmpl, dir_rows[i].typed, dir_rows[i].res);
      end
    end

    // Timestamp that wraps to exactly zero: a duplicate moves the index by one.
    wait_idle();
    write_cfg(REG_INTERVAL, 64'd100);
    write_cfg(REG_START, 64'd0 - (64'(pr_index) + 64'd1) * 64'd100);
    send_pkt(pr_last_seq, 1'b1, 1'b0, '0);
    send_pkt(pr_last_seq + 16'd1, 1'b1, 1'b0, '0);

    // Random phases, each with its own settings and idling pattern.
    gen_seq = pr_last_seq;
    for (int ph = 0; ph < 16; ph++) begin
      wait_idle();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      if (ph == 0) begin
        ival = 32'd1;
        tol = 32'd0;
        start = 64'd1;
      end else if (ph == 1) begin
        ival = 32'hFFFF_FFFF;
        tol = 32'hFFFF_FFFF;
        start = 64'hFFFF_FFFF_FFFF_FFFF;
      end else begin
        r = $urandom_range(9);
        if (r == 0) ival = 32'd0;
        else if (r < 3) ival = $urandom;
        else ival = $urandom_range(1, 20000);
        if ($urandom_range(7) == 0) tol = $urandom;
        else tol = $urandom_range(0, (ival >> 2) + 32'd8);
        r = $urandom_range(9);
        if (r == 0) start = 64'd0;
        else if (r < 3) start = {$urandom, $urandom};
        else start = 64'($urandom_range(1, 1000000));
      end
      write_cfg(REG_INTERVAL, 64'(ival));
      write_cfg(REG_TOLERANCE, 64'(tol));
      write_cfg(REG_START, start);

      for (int i = 0; i < 44; i++) begin
        // Now and then let everything drain and shift the origin a little.
        if (i != 0 && i % 11 == 0) begin
          wait_idle();
          if (pr_start != 64'd0)
            write_cfg(REG_START, pr_start + 64'($urandom_range(0, 2000)) - 64'd1000);
        end
        r = $urandom_range(99);
        if (r < 70) begin
          seq = gen_seq + 16'd1;
          gen_seq = seq;
        end else if (r < 85) begin
          seq = gen_seq + 16'($urandom_range(2, 40));
          gen_seq = seq;
        end else if (r < 90) begin
          seq = gen_seq;
        end else if (r < 95) begin
          seq = gen_seq - 16'($urandom_range(1, 20));
        end else begin
          seq = 16'($urandom);
          gen_seq = seq;
        end
        cmpl = ($urandom_range(9) != 0);
        send_pkt(seq, cmpl, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (150) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
